FILE: src/crr_pkg.sv
package crr_pkg;

  // field and datapath widths
  localparam int FIELD_W = 32;
  localparam int PROD_W = 64;
  localparam int RND_W = 34;
  localparam int WIDE_W = 48;
  localparam int CP_W = 34;
  localparam int MAG_W = 63;
  localparam int DEN_W = 32;

  // quotient is clamped to 2^40, so 41 bits are enough
  localparam int QUO_W = 41;
  localparam int QIDX_W = $clog2(QUO_W);
  localparam int TRIAL_W = DEN_W + QUO_W;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

  // configuration register indexes
  localparam logic [1:0] CFG_FOCAL_X = 2'd0;
  localparam logic [1:0] CFG_FOCAL_Y = 2'd1;
  localparam logic [1:0] CFG_CENTER_X = 2'd2;
  localparam logic [1:0] CFG_CENTER_Y = 2'd3;

  typedef struct packed {
    logic signed [FIELD_W-1:0] rot_x;
    logic signed [FIELD_W-1:0] rot_y;
    logic signed [FIELD_W-1:0] rot_z;
    logic signed [FIELD_W-1:0] rot_w;
    logic signed [FIELD_W-1:0] shift_x;
    logic signed [FIELD_W-1:0] shift_y;
    logic signed [FIELD_W-1:0] shift_z;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic signed [FIELD_W-1:0] point_z;
    logic signed [FIELD_W-1:0] pixel_u;
    logic signed [FIELD_W-1:0] pixel_v;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
    logic signed [FIELD_W-1:0] pixel_u;
    logic signed [FIELD_W-1:0] pixel_v;
  } point_t;

  typedef struct packed {
    logic neg_u;
    logic neg_v;
    logic ovf_u;
    logic ovf_v;
    logic dz;
    logic signed [CP_W-1:0] cp_u;
    logic signed [CP_W-1:0] cp_v;
  } proj_side_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] error_u;
    logic signed [FIELD_W-1:0] error_v;
    logic depth_zero;
    logic clipped;
  } result_t;

  // Q2.30 x Q16.16 product rounded half up to Q16.16
  function automatic logic signed [RND_W-1:0] qround(input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] s;
    s = prod + (PROD_W'(1) << 29);
    return s[PROD_W-1:30];
  endfunction

  // saturate to signed 32 bits
  function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32'sh7fffffff);
    lo = WIDE_W'(32'sh80000000);
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end else begin
      return x[FIELD_W-1:0];
    end
  endfunction

endpackage

FILE: src/camera_reprojection_residual.sv
// Pinhole reprojection residual. Each input transaction carries a quaternion
// (Q2.30, x,y,z,w order), a translation, a lidar point and the observed pixel
// (Q16.16); the block rotates and translates the point, projects it with the
// focal lengths and principal point from the configuration registers and
// returns projected minus observed pixel, saturated to signed Q16.16. The block
// takes one transaction per clock unless the output stalls; each passes the
// rotation, projection setup and 41-bit quotient (four bits per stage)
// stages and one output register. A zero depth gives zero residuals with
// depth_zero set. Configuration is written via cfg_we/cfg_index/cfg_data,
// by the user only while no transaction is in flight, unchecked by the block.
module camera_reprojection_residual (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // rot_x, rot_y, rot_z, rot_w, shift_x, shift_y, shift_z,
  // point_x, point_y, point_z, pixel_u, pixel_v
  input  logic [383:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // error_u, error_v
  output logic [63:0]  m_tdata,
  // depth_zero, clipped
  output logic [1:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [31:0]      focal_x, focal_y, center_x, center_y;
  crr_pkg::in_t     in_item;
  crr_pkg::point_t  point;
  crr_pkg::result_t res;
  logic             rot_valid;
  logic             rot_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= '0;
      focal_y <= '0;
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crr_pkg::CFG_FOCAL_X:  focal_x <= cfg_data;
        crr_pkg::CFG_FOCAL_Y:  focal_y <= cfg_data;
        crr_pkg::CFG_CENTER_X: center_x <= cfg_data;
        crr_pkg::CFG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the input transaction
  always_comb begin
    in_item.rot_x = s_tdata[31:0];
    in_item.rot_y = s_tdata[63:32];
    in_item.rot_z = s_tdata[95:64];
    in_item.rot_w = s_tdata[127:96];
    in_item.shift_x = s_tdata[159:128];
    in_item.shift_y = s_tdata[191:160];
    in_item.shift_z = s_tdata[223:192];
    in_item.point_x = s_tdata[255:224];
    in_item.point_y = s_tdata[287:256];
    in_item.point_z = s_tdata[319:288];
    in_item.pixel_u = s_tdata[351:320];
    in_item.pixel_v = s_tdata[383:352];
  end

  crr_rotate u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_point (point)
  );

  crr_project u_proj (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_point  (point),
    .focal_x   (focal_x),
    .focal_y   (focal_y),
    .center_x  (center_x),
    .center_y  (center_y),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {res.error_v, res.error_u};
  assign m_tuser = {res.clipped, res.depth_zero};

`ifndef SYNTHESIS
  // zero depth forces zero residuals and no clipping
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
    else $error("zero depth result not cleared");

  // clipping leaves at least one residual on a bound
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |->
      m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
      m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000)
    else $error("clipped set without a saturated residual");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule

FILE: src/crr_rotate.sv
// four-stage rotation and translation of the lidar point
module crr_rotate (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  crr_pkg::in_t    in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output crr_pkg::point_t out_point
);

  localparam int W = crr_pkg::FIELD_W;
  localparam int PW = crr_pkg::PROD_W;
  localparam int XW = crr_pkg::WIDE_W;

  logic [3:0] vld;
  logic [3:0] rdy;

  // stage 1: products for q x v
  logic signed [PW-1:0] m1 [6];
  logic signed [W-1:0]  q1 [3];
  logic signed [W-1:0]  w1;
  logic signed [W-1:0]  t1 [3];
  logic signed [W-1:0]  v1 [3];
  logic signed [W-1:0]  pu1, pv1;

  // stage 2: c = q x v
  logic signed [W-1:0]  c2 [3];
  logic signed [W-1:0]  q2 [3];
  logic signed [W-1:0]  w2;
  logic signed [W-1:0]  t2 [3];
  logic signed [W-1:0]  v2 [3];
  logic signed [W-1:0]  pu2, pv2;

  // stage 3: products for q x c and w*c
  logic signed [PW-1:0] n3 [6];
  logic signed [PW-1:0] g3 [3];
  logic signed [W-1:0]  t3 [3];
  logic signed [W-1:0]  v3 [3];
  logic signed [W-1:0]  pu3, pv3;

  // stage 4: transformed point
  logic signed [W-1:0]  d_next [3];
  logic signed [W-1:0]  p_next [3];
  crr_pkg::point_t      pt4;

  // ready chain from the output back
  always_comb begin
    rdy[3] = !vld[3] || out_ready;
    rdy[2] = !vld[2] || rdy[3];
    rdy[1] = !vld[1] || rdy[2];
    rdy[0] = !vld[0] || rdy[1];
  end

  assign in_ready = rdy[0];
  assign out_valid = vld[3];
  assign out_point = pt4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      m1[0] <= in_item.rot_y * in_item.point_z;
      m1[1] <= in_item.rot_z * in_item.point_y;
      m1[2] <= in_item.rot_z * in_item.point_x;
      m1[3] <= in_item.rot_x * in_item.point_z;
      m1[4] <= in_item.rot_x * in_item.point_y;
      m1[5] <= in_item.rot_y * in_item.point_x;
      q1[0] <= in_item.rot_x;
      q1[1] <= in_item.rot_y;
      q1[2] <= in_item.rot_z;
      w1 <= in_item.rot_w;
      t1[0] <= in_item.shift_x;
      t1[1] <= in_item.shift_y;
      t1[2] <= in_item.shift_z;
      v1[0] <= in_item.point_x;
      v1[1] <= in_item.point_y;
      v1[2] <= in_item.point_z;
      pu1 <= in_item.pixel_u;
      pv1 <= in_item.pixel_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        c2[i] <= crr_pkg::sat32(XW'(crr_pkg::qround(m1[2*i]))
                                - XW'(crr_pkg::qround(m1[2*i+1])));
        q2[i] <= q1[i];
        t2[i] <= t1[i];
        v2[i] <= v1[i];
      end
      w2 <= w1;
      pu2 <= pu1;
      pv2 <= pv1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      n3[0] <= q2[1] * c2[2];
      n3[1] <= q2[2] * c2[1];
      n3[2] <= q2[2] * c2[0];
      n3[3] <= q2[0] * c2[2];
      n3[4] <= q2[0] * c2[1];
      n3[5] <= q2[1] * c2[0];
      for (int i = 0; i < 3; i++) begin
        g3[i] <= w2 * c2[i];
        t3[i] <= t2[i];
        v3[i] <= v2[i];
      end
      pu3 <= pu2;
      pv3 <= pv2;
    end
  end

  // d = q x c, then p = v + 2 w c + 2 d + t
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_next[i] = crr_pkg::sat32(XW'(crr_pkg::qround(n3[2*i]))
                                 - XW'(crr_pkg::qround(n3[2*i+1])));
      p_next[i] = crr_pkg::sat32(XW'(v3[i])
                                 + XW'(crr_pkg::qround(g3[i])) * 48'sd2
                                 + XW'(d_next[i]) * 48'sd2
                                 + XW'(t3[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      pt4.x <= p_next[0];
      pt4.y <= p_next[1];
      pt4.z <= p_next[2];
      pt4.pixel_u <= pu3;
      pt4.pixel_v <= pv3;
    end
  end

endmodule

FILE: src/crr_divider.sv
// two-lane pipelined restoring divider, four quotient bits per stage
module crr_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [crr_pkg::MAG_W-1:0]         num_u,
  input  logic [crr_pkg::MAG_W-1:0]         num_v,
  input  logic [crr_pkg::DEN_W-1:0]         den,
  input  crr_pkg::proj_side_t               in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [crr_pkg::QUO_W-1:0]         quo_u,
  output logic [crr_pkg::QUO_W-1:0]         quo_v,
  output crr_pkg::proj_side_t               out_side
);

  localparam int NS = crr_pkg::DIV_STAGES;
  localparam int MW = crr_pkg::MAG_W;
  localparam int QW = crr_pkg::QUO_W;
  localparam int DW = crr_pkg::DEN_W;
  localparam int TW = crr_pkg::TRIAL_W;

  logic [NS-1:0]       vld;
  logic [NS-1:0]       rdy;
  logic [NS-1:0]       src_vld;
  logic [MW-1:0]       rem [NS][2];
  logic [QW-1:0]       quo [NS][2];
  logic [DW-1:0]       dreg [NS];
  crr_pkg::proj_side_t side [NS];
  logic [MW-1:0]       src_rem [NS][2];
  logic [QW-1:0]       src_quo [NS][2];
  logic [DW-1:0]       src_den [NS];
  crr_pkg::proj_side_t src_side [NS];
  logic [MW-1:0]       rem_next [NS][2];
  logic [QW-1:0]       quo_next [NS][2];

  // stage sources: ports for the first stage, registers after that
  always_comb begin
    src_vld[0] = in_valid;
    src_rem[0][0] = num_u;
    src_rem[0][1] = num_v;
    src_quo[0][0] = '0;
    src_quo[0][1] = '0;
    src_den[0] = den;
    src_side[0] = in_side;
    for (int s = 1; s < NS; s++) begin
      src_vld[s] = vld[s-1];
      src_rem[s] = rem[s-1];
      src_quo[s] = quo[s-1];
      src_den[s] = dreg[s-1];
      src_side[s] = side[s-1];
    end
  end

  // ready chain from the output back
  always_comb begin
    rdy[NS-1] = !vld[NS-1] || out_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  // quotient bits of each stage, most significant first
  always_comb begin
    logic [MW-1:0] r;
    logic [QW-1:0] qq;
    logic [TW-1:0] trial;
    int bi;
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < 2; l++) begin
        r = src_rem[s][l];
        qq = src_quo[s][l];
        for (int j = 0; j < crr_pkg::DIV_STEPS; j++) begin
          bi = QW - 1 - (s * crr_pkg::DIV_STEPS + j);
          if (bi >= 0) begin
            trial = TW'(src_den[s]) << bi;
            if (TW'(r) >= trial) begin
              r = r - trial[MW-1:0];
              qq[crr_pkg::QIDX_W'(bi)] = 1'b1;
            end
          end
        end
        rem_next[s][l] = r;
        quo_next[s][l] = qq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) vld[s] <= src_vld[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (rdy[s]) begin
        rem[s] <= rem_next[s];
        quo[s] <= quo_next[s];
        dreg[s] <= src_den[s];
        side[s] <= src_side[s];
      end
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = vld[NS-1];
  assign quo_u = quo[NS-1][0];
  assign quo_v = quo[NS-1][1];
  assign out_side = side[NS-1];

endmodule

FILE: src/crr_project.sv
// pinhole projection: focal products, sign and range split, divide, residual
module crr_project (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  crr_pkg::point_t             in_point,
  input  logic [crr_pkg::FIELD_W-1:0] focal_x,
  input  logic [crr_pkg::FIELD_W-1:0] focal_y,
  input  logic [crr_pkg::FIELD_W-1:0] center_x,
  input  logic [crr_pkg::FIELD_W-1:0] center_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output crr_pkg::result_t            out_res
);

  localparam int W = crr_pkg::FIELD_W;
  localparam int PW = crr_pkg::PROD_W;
  localparam int MW = crr_pkg::MAG_W;
  localparam int QW = crr_pkg::QUO_W;
  localparam int CW = crr_pkg::CP_W;
  localparam int TW = crr_pkg::TRIAL_W;
  localparam int SW = QW + 2;
  localparam int XW = crr_pkg::WIDE_W;
  localparam logic [QW-1:0] QLIM = QW'(1) << (QW - 1);

  logic [1:0] vld;
  logic [1:0] rdy;
  logic       div_ready;
  logic       div_valid;
  logic       fin_valid;
  logic       fin_ready;

  // stage 1: exact focal products
  logic signed [PW-1:0] prod_u1, prod_v1;
  logic signed [W-1:0]  den1;
  logic signed [CW-1:0] cp_u1, cp_v1;

  // stage 2: magnitudes, signs and overflow check
  logic [MW-1:0]        mag_u2, mag_v2;
  logic [W-1:0]         den2;
  crr_pkg::proj_side_t  side2;
  logic [MW-1:0]        mag_u_next, mag_v_next;
  logic [W-1:0]         den_next;

  // divider output and final residual
  logic [QW-1:0]        quo_u, quo_v;
  crr_pkg::proj_side_t  dside;
  crr_pkg::result_t     res_next;
  crr_pkg::result_t     res;

  always_comb begin
    rdy[1] = !vld[1] || div_ready;
    rdy[0] = !vld[0] || rdy[1];
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod_u1 <= $signed({1'b0, focal_x}) * in_point.x;
      prod_v1 <= $signed({1'b0, focal_y}) * in_point.y;
      den1 <= in_point.z;
      cp_u1 <= $signed({2'b00, center_x}) - CW'(in_point.pixel_u);
      cp_v1 <= $signed({2'b00, center_y}) - CW'(in_point.pixel_v);
    end
  end

  // absolute values; quotient at or above 2^41 is clamped anyway
  always_comb begin
    mag_u_next = prod_u1[PW-1] ? MW'(-prod_u1) : MW'(prod_u1);
    mag_v_next = prod_v1[PW-1] ? MW'(-prod_v1) : MW'(prod_v1);
    den_next = den1[W-1] ? W'(-den1) : W'(den1);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      mag_u2 <= mag_u_next;
      mag_v2 <= mag_v_next;
      den2 <= den_next;
      side2.neg_u <= prod_u1[PW-1] ^ den1[W-1];
      side2.neg_v <= prod_v1[PW-1] ^ den1[W-1];
      side2.ovf_u <= TW'(mag_u_next) >= {den_next, QW'(0)};
      side2.ovf_v <= TW'(mag_v_next) >= {den_next, QW'(0)};
      side2.dz <= den1 == '0;
      side2.cp_u <= cp_u1;
      side2.cp_v <= cp_v1;
    end
  end

  crr_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[1]),
    .in_ready  (div_ready),
    .num_u     (mag_u2),
    .num_v     (mag_v2),
    .den       (den2),
    .in_side   (side2),
    .out_valid (div_valid),
    .out_ready (fin_ready),
    .quo_u     (quo_u),
    .quo_v     (quo_v),
    .out_side  (dside)
  );

  // clamp, restore sign, add center minus pixel, saturate
  always_comb begin
    logic [QW-1:0]        qm_u, qm_v;
    logic signed [SW-1:0] sq_u, sq_v;
    logic signed [SW-1:0] sum_u, sum_v;
    logic signed [W-1:0]  e_u, e_v;
    qm_u = (dside.ovf_u || quo_u > QLIM) ? QLIM : quo_u;
    qm_v = (dside.ovf_v || quo_v > QLIM) ? QLIM : quo_v;
    sq_u = $signed({2'b00, qm_u});
    sq_v = $signed({2'b00, qm_v});
    if (dside.neg_u) sq_u = -sq_u;
    if (dside.neg_v) sq_v = -sq_v;
    sum_u = sq_u + SW'(dside.cp_u);
    sum_v = sq_v + SW'(dside.cp_v);
    e_u = crr_pkg::sat32(XW'(sum_u));
    e_v = crr_pkg::sat32(XW'(sum_v));
    if (dside.dz) begin
      res_next.error_u = '0;
      res_next.error_v = '0;
      res_next.depth_zero = 1'b1;
      res_next.clipped = 1'b0;
    end else begin
      res_next.error_u = e_u;
      res_next.error_v = e_v;
      res_next.depth_zero = 1'b0;
      res_next.clipped = (SW'(e_u) != sum_u) || (SW'(e_v) != sum_v);
    end
  end

  // output register
  assign fin_ready = !fin_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_ready) begin
      fin_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready) res <= res_next;
  end

  assign out_valid = fin_valid;
  assign out_res = res;

endmodule

FILE: verif/crr_checker.sv
`timescale 1ns / 1ps

module crr_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [383:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending_count,
  output int           result_count,
  output int           zero_depth_count,
  output int           clip_count
);

  typedef struct {
    logic signed [31:0] eu;
    logic signed [31:0] ev;
    logic               dz;
    logic               clip;
  } residual_t;

  residual_t residual_q[$];
  logic [31:0] fx, fy, cx, cy;

  function automatic longint clamp_s32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Q2.30 times Q16.16, round half up, floor shift
  function automatic longint round_mul(longint q, longint v);
    return (q * v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void cross_sat(longint q[3], longint a[3], output longint r[3]);
    r[0] = clamp_s32(round_mul(q[1], a[2]) - round_mul(q[2], a[1]));
    r[1] = clamp_s32(round_mul(q[2], a[0]) - round_mul(q[0], a[2]));
    r[2] = clamp_s32(round_mul(q[0], a[1]) - round_mul(q[1], a[0]));
  endfunction

  function automatic longint project_axis(logic [31:0] focal, longint num, longint den,
                                          logic [31:0] center, longint pix,
                                          inout logic clip);
    longint prod, quo, sum, res;
    prod = longint'({32'd0, focal}) * num;
    quo = prod / den;
    if (quo > (64'sd1 <<< 40)) quo = 64'sd1 <<< 40;
    if (quo < -(64'sd1 <<< 40)) quo = -(64'sd1 <<< 40);
    sum = quo + longint'({32'd0, center}) - pix;
    res = clamp_s32(sum);
    if (res != sum) clip = 1'b1;
    return res;
  endfunction

  function automatic residual_t predict_residual(logic [383:0] d);
    longint q[3], v[3], t[3], c[3], e[3], p[3];
    longint w;
    residual_t r;
    for (int i = 0; i < 3; i++) begin
      q[i] = longint'($signed(d[32*i +: 32]));
      t[i] = longint'($signed(d[32*(4+i) +: 32]));
      v[i] = longint'($signed(d[32*(7+i) +: 32]));
    end
    w = longint'($signed(d[96 +: 32]));
    cross_sat(q, v, c);
    cross_sat(q, c, e);
    for (int i = 0; i < 3; i++) begin
      p[i] = clamp_s32(v[i] + 2 * round_mul(w, c[i]) + 2 * e[i] + t[i]);
    end
    r.eu = 0;
    r.ev = 0;
    r.dz = 1'b0;
    r.clip = 1'b0;
    if (p[2] == 0) begin
      r.dz = 1'b1;
    end else begin
      r.eu = 32'(project_axis(fx, p[0], p[2], cx, longint'($signed(d[320 +: 32])), r.clip));
      r.ev = 32'(project_axis(fy, p[1], p[2], cy, longint'($signed(d[352 +: 32])), r.clip));
    end
    return r;
  endfunction

  // shadow registers, prediction and compare
  always @(posedge clk) begin
    residual_t want;
    if (rst) begin
      fx <= '0;
      fy <= '0;
      cx <= '0;
      cy <= '0;
      fail_count <= 0;
      pending_count <= 0;
      result_count <= 0;
      zero_depth_count <= 0;
      clip_count <= 0;
      residual_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          crr_pkg::CFG_FOCAL_X: fx <= cfg_data;
          crr_pkg::CFG_FOCAL_Y: fy <= cfg_data;
          crr_pkg::CFG_CENTER_X: cx <= cfg_data;
          crr_pkg::CFG_CENTER_Y: cy <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) residual_q.push_back(predict_residual(s_tdata));
      if (m_tvalid && m_tready) begin
        if (residual_q.size() == 0) begin
          $display("%0t: unexpected result transaction %h %b", $time, m_tdata, m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = residual_q.pop_front();
          result_count <= result_count + 1;
          if (want.dz) zero_depth_count <= zero_depth_count + 1;
          if (want.clip) clip_count <= clip_count + 1;
          if (m_tdata[31:0] !== want.eu || m_tdata[63:32] !== want.ev ||
              m_tuser[0] !== want.dz || m_tuser[1] !== want.clip) begin
            $display("%0t: expected eu=%h ev=%h dz=%b clip=%b, got eu=%h ev=%h dz=%b clip=%b",
                     $time, want.eu, want.ev, want.dz, want.clip,
                     m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= residual_q.size();
    end
  end

endmodule

FILE: verif/tb_camera_reprojection_residual.sv
`timescale 1ns / 1ps

module tb_camera_reprojection_residual;

  localparam int LATENCY = 18;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // rot_x, rot_y, rot_z, rot_w, shift_x, shift_y, shift_z,
  // point_x, point_y, point_z, pixel_u, pixel_v
  logic [383:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // error_u, error_v
  logic [63:0]  m_tdata;
  // depth_zero, clipped
  logic [1:0]   m_tuser;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  int fail_count, pending_count, result_count, zero_depth_count, clip_count;
  int cycle_count = 0;
  bit hold_off;
  bit hold_done;

  camera_reprojection_residual DUT (.*);

  crr_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  // random item; mostly quaternions with components within +-0.5 and points in front of the camera
  function automatic logic [383:0] rand_item();
    logic [383:0] d;
    for (int i = 0; i < 12; i++) d[32*i +: 32] = rand_word();
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < 4; i++)
        d[32*i +: 32] = 32'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
      for (int i = 4; i < 10; i++)
        d[32*i +: 32] = 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      d[32*9 +: 32] = 32'(int'($urandom_range(1 << 16, 1 << 22)));
      d[32*10 +: 32] = 32'($urandom_range(0, 1 << 27));
      d[32*11 +: 32] = 32'($urandom_range(0, 1 << 27));
    end
    return d;
  endfunction

  function automatic logic [383:0] make_item(logic [31:0] qx, logic [31:0] qy,
      logic [31:0] qz, logic [31:0] qw, logic [31:0] tz, logic [31:0] vx,
      logic [31:0] vz, logic [31:0] pu);
    return {32'h0010_0000, pu, vz, 32'h0001_0000, vx, tz, 32'h0, 32'h0, qw, qz, qy, qx};
  endfunction

  // write enable is dropped by set_camera after the last write
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_camera(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    write_reg(crr_pkg::CFG_FOCAL_X, a);
    write_reg(crr_pkg::CFG_FOCAL_Y, b);
    write_reg(crr_pkg::CFG_CENTER_X, c);
    write_reg(crr_pkg::CFG_CENTER_Y, d);
    cfg_we <= 1'b0;
  endtask

  // valid stays high after the transaction; the next call or drain decides
  task automatic send_item(logic [383:0] d);
    int n;
    n = gap_len();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // receiver stalls, one ready update per cycle, long hold-off when requested
  initial begin
    int idle_left;
    int busy_left;
    idle_left = 0;
    busy_left = 0;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off && !hold_done) begin
        hold_done = 1'b1;
        idle_left = 300;
        busy_left = 0;
      end
      if (idle_left == 0 && busy_left == 0) begin
        idle_left = gap_len();
        busy_left = $urandom_range(1, 12);
      end
      if (idle_left > 0) begin
        m_tready <= 1'b0;
        idle_left--;
      end else begin
        m_tready <= 1'b1;
        busy_left--;
      end
    end
  end

  initial begin
    logic [383:0] d;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset registers, then typical camera
    send_item(make_item(0, 0, 0, 32'h4000_0000, 0, 32'h0001_0000, 32'h0002_0000, 0));
    drain();
    set_camera(32'h0200_0000, 32'h0200_0000, 32'h0140_0000, 32'h00f0_0000);
    // identity, zero depth, negative depth
    send_item(make_item(0, 0, 0, 32'h4000_0000, 0, 32'h0001_0000, 32'h0004_0000, 32'h10000));
    send_item(make_item(0, 0, 0, 32'h4000_0000, 0, 32'h0001_0000, 32'h0, 0));
    send_item(make_item(0, 0, 0, 32'h4000_0000, 32'hffff_0000, 32'h0001_0000, 32'h0001_0000, 0));
    send_item(make_item(0, 0, 0, 32'h4000_0000, 0, 32'hffff_0000, 32'hfffe_0000, 32'h8000_0000));
    // 90 degree turns about each axis
    send_item(make_item(32'h2d41_3ccd, 0, 0, 32'h2d41_3ccd, 0, 32'h0001_0000,
                        32'h0003_0000, 32'h7fff_ffff));
    send_item(make_item(0, 32'h2d41_3ccd, 0, 32'h2d41_3ccd, 0, 32'h0001_0000, 32'h0003_0000, 0));
    send_item(make_item(0, 0, 32'h2d41_3ccd, 32'h2d41_3ccd, 32'h0005_0000, 32'h0002_0000, 0, 0));
    // extremes: saturation of intermediates and residual clipping
    send_item(make_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_item(make_item(0, 0, 0, 32'h4000_0000, 0, 32'h7fff_0000, 32'h0000_0001, 0));
    send_item(make_item(0, 0, 0, 32'h4000_0000, 0, 32'h8000_0000, 32'h0000_0001, 0));
    send_item({32'hffff_ffff, 32'hffff_ffff, {10{32'hffff_ffff}}});
    send_item('0);
    drain();
    set_camera(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(make_item(0, 0, 0, 32'h4000_0000, 0, 32'h7fff_ffff, 32'h0000_0001, 0));
    send_item(make_item(0, 0, 0, 32'h4000_0000, 0, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000));
    send_item(make_item(0, 0, 0, 32'h4000_0000, 0, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff));
    drain();

    // random phases with changing camera settings
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_camera(0, 0, 0, 0);
        1: set_camera(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        default: set_camera($urandom_range(0, 32'h0400_0000), $urandom_range(0, 32'h0400_0000),
                            $urandom, $urandom);
      endcase
      for (int i = 0; i < 110; i++) begin
        if (phase == 2 && i == 20) hold_off = 1;
        d = rand_item();
        if (phase == 2 && i >= 20 && i < 80) begin
          s_tvalid <= 1'b1;
          s_tdata <= d;
          do @(posedge clk); while (!s_tready);
        end else begin
          send_item(d);
        end
      end
      drain();
    end

    $display("checked %0d results, %0d zero depth, %0d clipped, over several camera settings",
             result_count, zero_depth_count, clip_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: camera_reprojection_residual.f
src/crr_pkg.sv
src/crr_rotate.sv
src/crr_divider.sv
src/crr_project.sv
src/camera_reprojection_residual.sv
verif/crr_checker.sv
verif/tb_camera_reprojection_residual.sv
